/* hdl/htsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package htsd_pkg;

    localparam int MAX_NODES        = 511;
    localparam int HEADER_BYTES     = 8;
    localparam int MAX_OUTPUT_BYTES = 16777216;
    localparam int MAX_INPUT_BYTES  = 16777215;
    localparam int LEAF_REC_BITS    = 9;
    localparam int INT_REC_BITS     = 21;
    localparam int REC_BITS_NUM     = 21;
    localparam int SIZE_SLACK       = 16;

    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_LENGTH    = 4'd0;
    localparam logic [3:0] ERR_SIZE      = 4'd1;
    localparam logic [3:0] ERR_COUNT     = 4'd2;
    localparam logic [3:0] ERR_ROOT      = 4'd3;
    localparam logic [3:0] ERR_SANITY    = 4'd4;
    localparam logic [3:0] ERR_EVEN_LINK = 4'd5;
    localparam logic [3:0] ERR_LINK_RNG  = 4'd6;
    localparam logic [3:0] ERR_INT_COUNT = 4'd7;
    localparam logic [3:0] ERR_BAD_TREE  = 4'd8;
    localparam logic [3:0] ERR_SHORT     = 4'd9;
    localparam logic [3:0] ERR_EXHAUSTED = 4'd10;
    localparam logic [3:0] ERR_GUARD     = 4'd11;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic [3:0] code;
    } result_t;

    typedef struct packed {
        logic emit;
        logic flush;
    } rb_ctrl_t;

endpackage

`default_nettype wire

/* hdl/htsd_result_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module htsd_result_buf
    import htsd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rb_ctrl_t ctrl,
    input  wire result_t  res,
    output logic          stall,
    output logic          m_valid,
    input  wire logic     m_ready,
    output logic [1:0]    m_kind,
    output logic [7:0]    m_symbol,
    output logic [3:0]    m_error_code,
    output logic          m_last
);

    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    out_last_reg;
    logic    push;
    logic    out_free;

    // newest result is held back until we know whether it closes the byte
    assign push     = (ctrl.emit || ctrl.flush) && pend_valid_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign stall    = push && !out_free;

    always_comb begin
        out_valid_next  = out_valid_reg && !m_ready;
        pend_valid_next = pend_valid_reg;
        if (push && out_free) begin
            out_valid_next = 1'b1;
        end
        if (!stall) begin
            if (ctrl.emit) begin
                pend_valid_next = 1'b1;
            end else if (ctrl.flush) begin
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && out_free) begin
            out_reg      <= pend_reg;
            out_last_reg <= ctrl.flush;
        end
        if (!stall && ctrl.emit) begin
            pend_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_reg.kind;
    assign m_symbol     = out_reg.symbol;
    assign m_error_code = out_reg.code;
    assign m_last       = out_last_reg;

endmodule

`default_nettype wire

/* hdl/huffman_tree_stream_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                  direction
// s_        s_valid, s_ready, s_in_byte            in, one container byte per item
// m_        m_valid, m_ready, m_kind, m_symbol,    out, one result per item
//           m_error_code, m_last
// cfg_      cfg_valid, cfg_ready, cfg_total_length in, stream length in bytes
//
// each byte is accepted, then taken whole in header phase or read bit by bit
// in table phase, then closed and flushed; in payload each bit also costs one
// registered node-table read.
// the tree check runs once per stream: a sweep clearing the symbol marks, then
// a visit of each reached node over node table and stack.
// reset is synchronous, active low; a full output register stalls the sequencer.

module huffman_tree_stream_decoder
    import htsd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_total_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_symbol,
    output logic [3:0]       m_error_code,
    output logic             m_last
);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_TABLE   = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_DONE    = 5'b01000,
        PH_ERROR   = 5'b10000
    } phase_t;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_HDR   = 15'b000000000000010,
        ST_TBIT  = 15'b000000000000100,
        ST_CLEAR = 15'b000000000001000,
        ST_DROOT = 15'b000000000010000,
        ST_DPOP  = 15'b000000000100000,
        ST_DIDX  = 15'b000000001000000,
        ST_DNODE = 15'b000000010000000,
        ST_DPUSH = 15'b000000100000000,
        ST_DSYM  = 15'b000001000000000,
        ST_PBIT  = 15'b000010000000000,
        ST_PWAIT = 15'b000100000000000,
        ST_PDONE = 15'b001000000000000,
        ST_SEND  = 15'b010000000000000,
        ST_FLUSH = 15'b100000000000000
    } state_t;

    // node entry: visited, leaf, child1, child0 (symbol in low byte for leaves)
    localparam int VIS_BIT  = 19;
    localparam int LEAF_BIT = 18;

    // memories
    logic [19:0] node_mem [512];
    logic [8:0]  stk_mem  [512];
    logic        sym_mem  [256];

    logic [19:0] node_q;
    logic [8:0]  stk_q;
    logic        sym_q;
    logic [8:0]  node_rd_addr, stk_rd_addr;
    logic [7:0]  sym_rd_addr;
    logic        node_we, stk_we, sym_we;
    logic [8:0]  node_wa, stk_wa;
    logic [7:0]  sym_wa;
    logic [19:0] node_wd;
    logic [8:0]  stk_wd;
    logic        sym_wd;

    // registers
    logic [23:0] total_length_reg;
    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [23:0] byte_count_reg, byte_count_next;
    logic [31:0] output_size_reg, output_size_next;
    logic [15:0] node_count_reg, node_count_next;
    logic [15:0] root_index_reg, root_index_next;
    logic [9:0]  record_count_reg, record_count_next;
    logic [9:0]  internal_count_reg, internal_count_next;
    logic [19:0] acc_reg, acc_next;
    logic [4:0]  fbc_reg, fbc_next;
    logic        leaf_rec_reg, leaf_rec_next;
    logic [8:0]  cur_node_reg, cur_node_next;
    logic [18:0] cur_entry_reg, cur_entry_next;
    logic [18:0] root_entry_reg, root_entry_next;
    logic [9:0]  walk_steps_reg, walk_steps_next;
    logic [31:0] symbols_done_reg, symbols_done_next;
    logic [7:0]  byte_reg, byte_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [9:0]  sp_reg, sp_next;
    logic [9:0]  leaves_reg, leaves_next;
    logic [9:0]  internals_reg, internals_next;
    logic [7:0]  clr_cnt_reg, clr_cnt_next;
    logic [8:0]  dfs_idx_reg, dfs_idx_next;
    logic [8:0]  c0_hold_reg, c0_hold_next;
    logic [7:0]  sym_addr_reg, sym_addr_next;
    logic        root_first_reg, root_first_next;
    logic        short_reg, short_next;

    // sequencer helpers
    logic        go;
    logic        rb_stall;
    rb_ctrl_t    rb_ctrl;
    result_t     res;
    logic        do_fail;
    logic [3:0]  fail_code;
    logic        advance;
    state_t      adv_state;

    logic        bit_val;
    logic [9:0]  records;
    logic [19:0] acc_new;
    logic [4:0]  fbc_inc;
    logic [4:0]  rec_need;
    logic [9:0]  raw1, raw0;
    logic [8:0]  c1, c0;
    logic [9:0]  rec_inc;
    logic [9:0]  internal_new;
    logic [26:0] consumed;
    logic [32:0] bits_needed;
    logic        short_calc;
    logic [23:0] body;
    logic [13:0] rec21;
    logic [10:0] tree_bytes;
    logic [32:0] size_limit;
    logic [15:0] root_full;
    logic [8:0]  next_node;
    logic [9:0]  ws_inc;
    logic [31:0] sd_inc;
    logic [23:0] bc_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign go        = !rb_stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_length_reg <= 24'd0;
        end else if (cfg_valid) begin
            total_length_reg <= cfg_total_length;
        end
    end

    // datapath terms
    assign bit_val      = byte_reg[bit_idx_reg];
    assign records      = node_count_reg[9:0] + 10'd1;
    assign acc_new      = acc_reg | (20'(bit_val) << (fbc_reg - 5'd1));
    assign fbc_inc      = fbc_reg + 5'd1;
    assign rec_need     = leaf_rec_reg ? 5'(LEAF_REC_BITS) : 5'(INT_REC_BITS);
    assign raw1         = acc_new[9:0];
    assign raw0         = acc_new[19:10];
    assign c1           = raw1[9:1];
    assign c0           = raw0[9:1];
    assign rec_inc      = record_count_reg + 10'd1;
    assign internal_new = internal_count_reg + (leaf_rec_reg ? 10'd0 : 10'd1);
    assign consumed     = {byte_count_reg, 3'b000} + 27'(4'd8 - {1'b0, bit_idx_reg});
    assign bits_needed  = 33'(consumed) + 33'(output_size_reg);
    // payload bits left are fewer than the symbols still owed
    assign short_calc   = 33'({total_length_reg, 3'b000}) < bits_needed;
    assign body         = (total_length_reg >= 24'(HEADER_BYTES))
                          ? total_length_reg - 24'(HEADER_BYTES) : 24'd0;
    assign rec21        = 14'(records) * 14'(REC_BITS_NUM);
    assign tree_bytes   = 11'((rec21 + 14'd7) >> 3);
    assign size_limit   = 33'(output_size_reg) + 33'(tree_bytes) + 33'(SIZE_SLACK);
    assign root_full    = {byte_reg, root_index_reg[7:0]};
    assign next_node    = bit_val ? cur_entry_reg[17:9] : cur_entry_reg[8:0];
    assign ws_inc       = walk_steps_reg + 10'd1;
    assign sd_inc       = symbols_done_reg + 32'd1;
    assign bc_inc       = byte_count_reg + 24'd1;

    always_comb begin
        state_next          = state_reg;
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        output_size_next    = output_size_reg;
        node_count_next     = node_count_reg;
        root_index_next     = root_index_reg;
        record_count_next   = record_count_reg;
        internal_count_next = internal_count_reg;
        acc_next            = acc_reg;
        fbc_next            = fbc_reg;
        leaf_rec_next       = leaf_rec_reg;
        cur_node_next       = cur_node_reg;
        cur_entry_next      = cur_entry_reg;
        root_entry_next     = root_entry_reg;
        walk_steps_next     = walk_steps_reg;
        symbols_done_next   = symbols_done_reg;
        byte_next           = byte_reg;
        bit_idx_next        = bit_idx_reg;
        sp_next             = sp_reg;
        leaves_next         = leaves_reg;
        internals_next      = internals_reg;
        clr_cnt_next        = clr_cnt_reg;
        dfs_idx_next        = dfs_idx_reg;
        c0_hold_next        = c0_hold_reg;
        sym_addr_next       = sym_addr_reg;
        root_first_next     = root_first_reg;
        short_next          = short_reg;

        node_rd_addr = dfs_idx_reg;
        stk_rd_addr  = 9'(sp_reg - 10'd1);
        sym_rd_addr  = sym_addr_reg;
        node_we      = 1'b0;
        node_wa      = record_count_reg[8:0];
        node_wd      = 20'd0;
        stk_we       = 1'b0;
        stk_wa       = sp_reg[8:0];
        stk_wd       = 9'd0;
        sym_we       = 1'b0;
        sym_wa       = clr_cnt_reg;
        sym_wd       = 1'b0;

        rb_ctrl   = '0;
        res       = '0;
        do_fail   = 1'b0;
        fail_code = ERR_LENGTH;
        advance   = 1'b0;
        adv_state = ST_TBIT;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next    = s_in_byte;
                    bit_idx_next = 3'd7;
                    unique case (phase_reg)
                        PH_HEADER:  state_next = ST_HDR;
                        PH_TABLE:   state_next = ST_TBIT;
                        PH_PAYLOAD: state_next = ST_PBIT;
                        default:    state_next = ST_SEND;
                    endcase
                end
            end

            ST_HDR: begin
                state_next = ST_SEND;
                if (byte_count_reg == 24'd0
                    && (total_length_reg <= 24'(HEADER_BYTES + 2)
                        || 25'(total_length_reg) > 25'(MAX_INPUT_BYTES))) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LENGTH;
                end else begin
                    case (byte_count_reg[2:0])
                        3'd0: output_size_next[7:0]   = byte_reg;
                        3'd1: output_size_next[15:8]  = byte_reg;
                        3'd2: output_size_next[23:16] = byte_reg;
                        3'd3: output_size_next[31:24] = byte_reg;
                        3'd4: node_count_next[7:0]    = byte_reg;
                        3'd5: node_count_next[15:8]   = byte_reg;
                        3'd6: root_index_next[7:0]    = byte_reg;
                        default: root_index_next[15:8] = byte_reg;
                    endcase
                    if (byte_count_reg == 24'(HEADER_BYTES - 1)) begin
                        // checks in order: size, count, root, length sanity
                        if (output_size_reg == 32'd0
                            || output_size_reg > 32'(MAX_OUTPUT_BYTES)) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_SIZE;
                        end else if (node_count_reg < 16'd3
                                     || node_count_reg > 16'(MAX_NODES)) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_COUNT;
                        end else if (root_full > node_count_reg) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_ROOT;
                        end else if (33'(body) > size_limit) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_SANITY;
                        end else begin
                            phase_next          = PH_TABLE;
                            record_count_next   = 10'd0;
                            internal_count_next = 10'd0;
                            fbc_next            = 5'd0;
                            acc_next            = 20'd0;
                        end
                    end
                end
            end

            ST_TBIT: begin
                if (fbc_reg == 5'd0) begin
                    // flag bit opens a record
                    leaf_rec_next = bit_val;
                    acc_next      = 20'd0;
                    fbc_next      = 5'd1;
                    advance       = 1'b1;
                end else begin
                    acc_next = acc_new;
                    fbc_next = fbc_inc;
                    if (fbc_inc != rec_need) begin
                        advance = 1'b1;
                    end else begin
                        fbc_next = 5'd0;
                        if (!leaf_rec_reg && (!raw1[0] || !raw0[0])) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_EVEN_LINK;
                        end else if (!leaf_rec_reg && ({1'b0, c1} >= records
                                                       || {1'b0, c0} >= records)) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_LINK_RNG;
                        end else begin
                            node_we = 1'b1;
                            node_wa = record_count_reg[8:0];
                            node_wd = leaf_rec_reg ? {2'b01, 10'd0, acc_new[7:0]}
                                                   : {2'b00, c1, c0};
                            internal_count_next = internal_new;
                            record_count_next   = rec_inc;
                            if (rec_inc >= records) begin
                                // table complete: count check, then tree check
                                if (internal_new != {1'b0, node_count_reg[9:1]}) begin
                                    do_fail   = 1'b1;
                                    fail_code = ERR_INT_COUNT;
                                end else begin
                                    short_next   = short_calc;
                                    clr_cnt_next = 8'd0;
                                    state_next   = ST_CLEAR;
                                end
                            end else begin
                                advance = 1'b1;
                            end
                        end
                    end
                end
            end

            ST_CLEAR: begin
                // sweep the symbol marks, one entry a cycle
                sym_we       = 1'b1;
                sym_wa       = clr_cnt_reg;
                sym_wd       = 1'b0;
                clr_cnt_next = clr_cnt_reg + 8'd1;
                if (clr_cnt_reg == 8'hFF) begin
                    sp_next         = 10'd0;
                    leaves_next     = 10'd0;
                    internals_next  = 10'd0;
                    root_first_next = 1'b1;
                    state_next      = ST_DROOT;
                end
            end

            ST_DROOT: begin
                node_rd_addr = root_index_reg[8:0];
                dfs_idx_next = root_index_reg[8:0];
                state_next   = ST_DNODE;
            end

            ST_DPOP: begin
                if (sp_reg == 10'd0) begin
                    if (leaves_reg != internals_reg + 10'd1 || leaves_reg < 10'd2) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_BAD_TREE;
                    end else if (short_reg) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_SHORT;
                    end else begin
                        phase_next        = PH_PAYLOAD;
                        cur_node_next     = root_index_reg[8:0];
                        cur_entry_next    = root_entry_reg;
                        walk_steps_next   = 10'd0;
                        symbols_done_next = 32'd0;
                        advance           = 1'b1;
                        adv_state         = ST_PBIT;
                    end
                end else begin
                    stk_rd_addr = 9'(sp_reg - 10'd1);
                    sp_next     = sp_reg - 10'd1;
                    state_next  = ST_DIDX;
                end
            end

            ST_DIDX: begin
                node_rd_addr = stk_q;
                dfs_idx_next = stk_q;
                state_next   = ST_DNODE;
            end

            ST_DNODE: begin
                node_rd_addr    = dfs_idx_reg;
                root_first_next = 1'b0;
                if (root_first_reg) begin
                    root_entry_next = node_q[18:0];
                end
                if ((root_first_reg && node_q[LEAF_BIT]) || node_q[VIS_BIT]) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_TREE;
                end else begin
                    node_we = 1'b1;
                    node_wa = dfs_idx_reg;
                    node_wd = {1'b1, node_q[18:0]};
                    if (node_q[LEAF_BIT]) begin
                        sym_rd_addr   = node_q[7:0];
                        sym_addr_next = node_q[7:0];
                        state_next    = ST_DSYM;
                    end else begin
                        internals_next = internals_reg + 10'd1;
                        if (node_q[17:9] == node_q[8:0]
                            || 11'(sp_reg) + 11'd2 > 11'(records)) begin
                            do_fail   = 1'b1;
                            fail_code = ERR_BAD_TREE;
                        end else begin
                            stk_we       = 1'b1;
                            stk_wa       = sp_reg[8:0];
                            stk_wd       = node_q[17:9];
                            c0_hold_next = node_q[8:0];
                            state_next   = ST_DPUSH;
                        end
                    end
                end
            end

            ST_DPUSH: begin
                stk_we     = 1'b1;
                stk_wa     = sp_reg[8:0] + 9'd1;
                stk_wd     = c0_hold_reg;
                sp_next    = sp_reg + 10'd2;
                state_next = ST_DPOP;
            end

            ST_DSYM: begin
                sym_rd_addr = sym_addr_reg;
                if (sym_q) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_TREE;
                end else begin
                    sym_we      = 1'b1;
                    sym_wa      = sym_addr_reg;
                    sym_wd      = 1'b1;
                    leaves_next = leaves_reg + 10'd1;
                    state_next  = ST_DPOP;
                end
            end

            ST_PBIT: begin
                if (ws_inc > records) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_GUARD;
                end else begin
                    walk_steps_next = ws_inc;
                    cur_node_next   = next_node;
                    node_rd_addr    = next_node;
                    state_next      = ST_PWAIT;
                end
            end

            ST_PWAIT: begin
                node_rd_addr = cur_node_reg;
                if (node_q[LEAF_BIT]) begin
                    rb_ctrl.emit      = 1'b1;
                    res.kind          = KIND_SYMBOL;
                    res.symbol        = node_q[7:0];
                    symbols_done_next = sd_inc;
                    cur_node_next     = root_index_reg[8:0];
                    cur_entry_next    = root_entry_reg;
                    walk_steps_next   = 10'd0;
                    if (sd_inc == output_size_reg) begin
                        state_next = ST_PDONE;
                    end else begin
                        advance   = 1'b1;
                        adv_state = ST_PBIT;
                    end
                end else begin
                    cur_entry_next = node_q[18:0];
                    advance        = 1'b1;
                    adv_state      = ST_PBIT;
                end
            end

            ST_PDONE: begin
                rb_ctrl.emit = 1'b1;
                res.kind     = KIND_DONE;
                phase_next   = PH_DONE;
                state_next   = ST_SEND;
            end

            ST_SEND: begin
                state_next = ST_FLUSH;
                if (bc_inc >= total_length_reg) begin
                    // stream end: unfinished streams report exhaustion
                    if (phase_reg == PH_HEADER || phase_reg == PH_TABLE
                        || phase_reg == PH_PAYLOAD) begin
                        rb_ctrl.emit = 1'b1;
                        res.kind     = KIND_ERROR;
                        res.code     = ERR_EXHAUSTED;
                    end
                    phase_next          = PH_HEADER;
                    byte_count_next     = 24'd0;
                    output_size_next    = 32'd0;
                    node_count_next     = 16'd0;
                    root_index_next     = 16'd0;
                    record_count_next   = 10'd0;
                    internal_count_next = 10'd0;
                    acc_next            = 20'd0;
                    fbc_next            = 5'd0;
                    leaf_rec_next       = 1'b0;
                    cur_node_next       = 9'd0;
                    walk_steps_next     = 10'd0;
                    symbols_done_next   = 32'd0;
                end else begin
                    byte_count_next = bc_inc;
                end
            end

            ST_FLUSH: begin
                rb_ctrl.flush = 1'b1;
                state_next    = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next bit of the byte, or close the byte
        if (advance) begin
            if (bit_idx_reg == 3'd0) begin
                state_next = ST_SEND;
            end else begin
                bit_idx_next = bit_idx_reg - 3'd1;
                state_next   = adv_state;
            end
        end

        if (do_fail) begin
            rb_ctrl.emit = 1'b1;
            res.kind     = KIND_ERROR;
            res.symbol   = 8'd0;
            res.code     = fail_code;
            phase_next   = PH_ERROR;
            state_next   = ST_SEND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            phase_reg          <= PH_HEADER;
            byte_count_reg     <= 24'd0;
            output_size_reg    <= 32'd0;
            node_count_reg     <= 16'd0;
            root_index_reg     <= 16'd0;
            record_count_reg   <= 10'd0;
            internal_count_reg <= 10'd0;
            acc_reg            <= 20'd0;
            fbc_reg            <= 5'd0;
            leaf_rec_reg       <= 1'b0;
            cur_node_reg       <= 9'd0;
            cur_entry_reg      <= 19'd0;
            root_entry_reg     <= 19'd0;
            walk_steps_reg     <= 10'd0;
            symbols_done_reg   <= 32'd0;
            bit_idx_reg        <= 3'd0;
            sp_reg             <= 10'd0;
            leaves_reg         <= 10'd0;
            internals_reg      <= 10'd0;
            clr_cnt_reg        <= 8'd0;
            root_first_reg     <= 1'b0;
            short_reg          <= 1'b0;
        end else if (go) begin
            state_reg          <= state_next;
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            output_size_reg    <= output_size_next;
            node_count_reg     <= node_count_next;
            root_index_reg     <= root_index_next;
            record_count_reg   <= record_count_next;
            internal_count_reg <= internal_count_next;
            acc_reg            <= acc_next;
            fbc_reg            <= fbc_next;
            leaf_rec_reg       <= leaf_rec_next;
            cur_node_reg       <= cur_node_next;
            cur_entry_reg      <= cur_entry_next;
            root_entry_reg     <= root_entry_next;
            walk_steps_reg     <= walk_steps_next;
            symbols_done_reg   <= symbols_done_next;
            bit_idx_reg        <= bit_idx_next;
            sp_reg             <= sp_next;
            leaves_reg         <= leaves_next;
            internals_reg      <= internals_next;
            clr_cnt_reg        <= clr_cnt_next;
            root_first_reg     <= root_first_next;
            short_reg          <= short_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (go) begin
            byte_reg     <= byte_next;
            dfs_idx_reg  <= dfs_idx_next;
            c0_hold_reg  <= c0_hold_next;
            sym_addr_reg <= sym_addr_next;
        end
    end

    // node table, walk stack and symbol marks: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (node_we && go) begin
            node_mem[node_wa] <= node_wd;
        end
        node_q <= node_mem[node_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we && go) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_q <= stk_mem[stk_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (sym_we && go) begin
            sym_mem[sym_wa] <= sym_wd;
        end
        sym_q <= sym_mem[sym_rd_addr];
    end

    htsd_result_buf u_result_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (rb_ctrl),
        .res          (res),
        .stall        (rb_stall),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_symbol     (m_symbol),
        .m_error_code (m_error_code),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
